/* src/text_tokenizer_stem_stopword_top_assert.svh */
// assertion macros shared by the tokenizer modules
`ifndef TEXT_TOKENIZER_STEM_STOPWORD_TOP_ASSERT_SVH
`define TEXT_TOKENIZER_STEM_STOPWORD_TOP_ASSERT_SVH

// same-cycle implication, checked at every clock outside reset
`define TS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every clock outside reset
`define TS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tokstem_pkg.sv */
// shared types, constants and helper functions of the tokenizer
package tokstem_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 24;
    localparam int CIDX_W    = 5;
    localparam int LEN_W     = 8;
    localparam int EMIT_W    = 7;
    localparam int NUM_STOPS = 16;

    localparam logic [LEN_W-1:0] LEN_SAT   = 8'd255;
    localparam logic [LEN_W-1:0] STEM_MIN  = 8'd4;
    localparam logic [LEN_W-1:0] HEAD_LEN  = 8'd4;

    localparam logic [23:0] SUF_ING = 24'h696e67;
    localparam logic [15:0] SUF_ED  = 16'h6564;
    localparam logic [15:0] SUF_ES  = 16'h6573;
    localparam logic [7:0]  SUF_S   = 8'h73;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_EOT  = 1'b1;

    // first character in the low byte
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] text;
    } t_stop;

    localparam t_stop STOP_LIST [NUM_STOPS] = '{
        '{3'd1, 32'h00000061}, '{3'd2, 32'h00006e61}, '{3'd3, 32'h00656874},
        '{3'd3, 32'h00646e61}, '{3'd2, 32'h0000726f}, '{3'd2, 32'h00006f74},
        '{3'd2, 32'h0000666f}, '{3'd2, 32'h00006e69}, '{3'd2, 32'h00006e6f},
        '{3'd3, 32'h00726f66}, '{3'd2, 32'h00007369}, '{3'd2, 32'h00007469},
        '{3'd4, 32'h68746977}, '{3'd2, 32'h00007361}, '{3'd2, 32'h00007962},
        '{3'd2, 32'h00006562}
    };

    typedef struct packed {
        logic              bank;
        logic [EMIT_W-1:0] emit_len;
        logic [POS_W-1:0]  position;
        logic              cut;
    } t_job;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_stop(input logic [LEN_W-1:0] len,
                                     input logic [31:0] head);
        logic [31:0] mask;
        logic        hit;
        mask = '0;
        hit  = 1'b0;
        for (int b = 0; b < 4; b++) begin
            if (LEN_W'(b) < len) begin
                mask[b*8 +: 8] = 8'hff;
            end
        end
        for (int k = 0; k < NUM_STOPS; k++) begin
            if (len == LEN_W'(STOP_LIST[k].len) && (head & mask) == STOP_LIST[k].text) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

/* src/tokstem_if.sv */
// valid/ready channels for text bytes in and term characters out
interface tokstem_in_if;
    import tokstem_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output req_type, output text_byte, input ready);
    modport sink   (input valid, input req_type, input text_byte, output ready);
endinterface

interface tokstem_out_if;
    import tokstem_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] term_char;
    logic [CIDX_W-1:0] char_index;
    logic [POS_W-1:0]  word_position;
    logic              last_char;
    logic              truncated;

    modport source (output valid, output term_char, output char_index, output word_position,
                    output last_char, output truncated, input ready);
    modport sink   (input valid, input term_char, input char_index, input word_position,
                    input last_char, input truncated, output ready);
endinterface

/* src/tokstem_ram.sv */
// generic single-write, single-read ram with registered read data
module tokstem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/tokstem_queue.sv */
// two-entry queue of closed words waiting for replay
`include "text_tokenizer_stem_stopword_top_assert.svh"

module tokstem_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tokstem_pkg::t_job  i_job,
    input  logic               i_pop,
    output logic               o_empty,
    output tokstem_pkg::t_job  o_head
);
    import tokstem_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd];

    `TS_ASSERT_NOW(a_no_overflow, i_push, r_count != 2'd2, "push into full queue")
    `TS_ASSERT_NOW(a_no_underflow, i_pop, r_count != 2'd0, "pop from empty queue")
    `TS_ASSERT_NEXT(a_push_fills, i_push && !i_pop, !o_empty, "pushed item lost")

endmodule

/* src/tokstem_front.sv */
// front end: classifies bytes, builds words, stems and filters closed words
module tokstem_front #(
    parameter int MAX_WORD = 32,
    localparam int IDX_W = $clog2(MAX_WORD)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tokstem_in_if.sink                    i_tok,
    input  logic                          i_stem_en,
    output logic                          o_wr_en,
    output logic [IDX_W:0]                o_wr_addr,
    output logic [tokstem_pkg::BYTE_W-1:0] o_wr_data,
    output logic                          o_push,
    output tokstem_pkg::t_job             o_job,
    input  tokstem_pkg::t_done            i_done
);
    import tokstem_pkg::*;

    logic [LEN_W-1:0]  r_len;
    logic [23:0]       r_tail;
    logic [31:0]       r_head;
    logic [POS_W-1:0]  r_pos;
    logic              r_wb;
    logic [1:0]        r_busy;

    logic [LEN_W-1:0]  n_len;
    logic [23:0]       n_tail;
    logic [POS_W-1:0]  n_pos;
    logic              n_wb;
    logic [1:0]        n_busy;

    logic [BYTE_W-1:0] c_low;
    logic              acc;
    logic              take_char;
    logic              close;
    logic [LEN_W-1:0]  stem_len;
    logic              cut;
    logic [EMIT_W-1:0] emit;
    logic              stop;

    assign c_low     = to_lower(i_tok.text_byte);
    assign i_tok.ready = ~r_busy[r_wb];
    assign acc       = i_tok.valid & i_tok.ready;
    assign take_char = acc && i_tok.req_type == REQ_BYTE && is_alnum(c_low);
    assign close     = acc && !take_char;

    always_comb begin
        stem_len = r_len;
        if (i_stem_en && r_len > STEM_MIN) begin
            if (r_tail == SUF_ING) begin
                stem_len = r_len - 8'd3;
            end else if (r_tail[15:0] == SUF_ED || r_tail[15:0] == SUF_ES) begin
                stem_len = r_len - 8'd2;
            end else if (r_tail[7:0] == SUF_S) begin
                stem_len = r_len - 8'd1;
            end
        end
    end

    assign cut  = stem_len > LEN_W'(MAX_WORD);
    assign emit = cut ? EMIT_W'(MAX_WORD) : stem_len[EMIT_W-1:0];
    assign stop = !cut && is_stop(stem_len, r_head);

    assign o_push         = close && r_len != '0 && !stop;
    assign o_job.bank     = r_wb;
    assign o_job.emit_len = emit;
    assign o_job.position = r_pos;
    assign o_job.cut      = cut;

    assign o_wr_en   = take_char && r_len < LEN_W'(MAX_WORD);
    assign o_wr_addr = {r_wb, r_len[IDX_W-1:0]};
    assign o_wr_data = c_low;

    always_comb begin
        n_len  = r_len;
        n_tail = r_tail;
        n_pos  = r_pos;
        n_wb   = r_wb;
        n_busy = r_busy;
        if (i_done.valid) begin
            n_busy[i_done.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_wb] = 1'b1;
            n_wb         = ~r_wb;
        end
        if (take_char) begin
            if (r_len != LEN_SAT) begin
                n_len = r_len + 8'd1;
            end
            n_tail = {r_tail[15:0], c_low};
        end
        if (close) begin
            n_len  = '0;
            n_tail = '0;
            if (r_len != '0) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (i_tok.req_type == REQ_EOT) begin
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_tail <= '0;
            r_pos  <= '0;
            r_wb   <= 1'b0;
            r_busy <= 2'b00;
        end else begin
            r_len  <= n_len;
            r_tail <= n_tail;
            r_pos  <= n_pos;
            r_wb   <= n_wb;
            r_busy <= n_busy;
        end
    end

    // first four characters kept for the stop list check
    always_ff @(posedge i_clk) begin
        if (take_char && r_len < HEAD_LEN) begin
            r_head[r_len[1:0]*8 +: 8] <= c_low;
        end
    end

endmodule

/* src/tokstem_back.sv */
// back end: replays queued words from the buffer one character per item
`include "text_tokenizer_stem_stopword_top_assert.svh"

module tokstem_back #(
    parameter int MAX_WORD = 32,
    localparam int IDX_W = $clog2(MAX_WORD)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  tokstem_pkg::t_job              i_job,
    output logic                           o_pop,
    output tokstem_pkg::t_done             o_done,
    output logic [IDX_W:0]                 o_rd_addr,
    input  logic [tokstem_pkg::BYTE_W-1:0] i_rd_data,
    tokstem_out_if.source                  o_term
);
    import tokstem_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_LOAD, S_OUT} t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_char;
    logic [CIDX_W-1:0] r_cidx;
    logic [POS_W-1:0]  r_pos;
    logic              r_last;
    logic              r_cut;

    assign o_rd_addr   = {i_job.bank, r_idx};
    assign o_pop       = r_state == S_OUT && o_term.ready && r_last;
    assign o_done.valid = o_pop;
    assign o_done.bank  = i_job.bank;

    assign o_term.valid         = r_valid;
    assign o_term.term_char     = r_char;
    assign o_term.char_index    = r_cidx;
    assign o_term.word_position = r_pos;
    assign o_term.last_char     = r_last;
    assign o_term.truncated     = r_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_char  <= i_rd_data;
                    r_cidx  <= CIDX_W'(r_idx);
                    r_pos   <= i_job.position;
                    r_last  <= (EMIT_W'(r_idx) + EMIT_W'(1)) == i_job.emit_len;
                    r_cut   <= i_job.cut;
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_term.ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= IDX_W'(r_idx + 1'b1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TS_ASSERT_NOW(a_job_present, r_state != S_IDLE, !i_empty, "replay without queued word")
    `TS_ASSERT_NOW(a_idx_in_word, r_valid, EMIT_W'(r_idx) < i_job.emit_len, "index past term")
    `TS_ASSERT_NEXT(a_pop_clears, o_pop, !r_valid, "item still shown after word end")

endmodule

/* src/text_tokenizer_stem_stopword_top.sv */
// top level: apb register, front end, word queue, buffer ram and back end
// a term's first character is shown once its word has passed the queue and the read and load states
// input: one byte per cycle while a buffer bank is free; two banks hold closed words
// output: each character passes the read, load and hand-off states; the back end idles between terms
// reset: synchronous active low, clears control state, position, length and stem_enable
// the word buffer is not cleared; only written entries are read back
module text_tokenizer_stem_stopword_top #(
    parameter int MAX_WORD = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tokstem_in_if.sink   i_tok,
    tokstem_out_if.source o_term,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tokstem_pkg::*;

    localparam int IDX_W = $clog2(MAX_WORD);
    localparam logic REG_STEM = 1'b0;

    logic              r_stem_en;
    logic              wr_en;
    logic [IDX_W:0]    wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [IDX_W:0]    rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              push;
    logic              pop;
    logic              empty;
    t_job              job_in;
    t_job              job_head;
    t_done             done;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STEM) ? {31'd0, r_stem_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stem_en <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEM) begin
            r_stem_en <= pwdata[0];
        end
    end

    tokstem_front #(.MAX_WORD(MAX_WORD)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tok     (i_tok),
        .i_stem_en (r_stem_en),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_push    (push),
        .o_job     (job_in),
        .i_done    (done)
    );

    tokstem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (job_head)
    );

    tokstem_ram #(.WIDTH(BYTE_W), .DEPTH(2 << IDX_W)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tokstem_back #(.MAX_WORD(MAX_WORD)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_job     (job_head),
        .o_pop     (pop),
        .o_done    (done),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_term    (o_term)
    );

endmodule
